>>> rtl/core/bmpw_pkg.sv
// Package for the BMP pixel stream writer: payload types, configuration indexes,
// header constants and the command and status structs shared by the controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bmpw_pkg;

  localparam int unsigned DATA_W         = 16;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned CFG_W          = 13;
  localparam int unsigned CFG_IDX_W      = 1;
  localparam int unsigned MAX_SIDE_DEF   = 4096;
  localparam int unsigned FRAC_BITS_DEF  = 12;

  localparam logic [CFG_W-1:0] SIDE_RESET = 13'd64;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam int unsigned HDR_BYTES      = 54;
  localparam int unsigned INFO_BYTES     = 40;
  localparam int unsigned BITS_PER_PIXEL = 24;
  localparam int unsigned PLANES         = 1;
  localparam int unsigned PIXEL_BYTES    = 3;
  localparam int unsigned BYTE_CNT_W     = 6;

  localparam logic [BYTE_W-1:0] MAGIC_B = 8'h42;
  localparam logic [BYTE_W-1:0] MAGIC_M = 8'h4D;

  localparam logic [1:0] SEL_HDR = 2'd0;
  localparam logic [1:0] SEL_PIX = 2'd1;
  localparam logic [1:0] SEL_PAD = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] red_linear;
    logic signed [DATA_W-1:0] green_linear;
    logic signed [DATA_W-1:0] blue_linear;
  } pixel_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              file_last;
  } bmp_word_t;

  typedef struct packed {
    logic       load;
    logic       root_step;
    logic       emit;
    logic [1:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic root_done;
    logic need_hdr;
    logic need_pad;
    logic out_free;
    logic phase_last;
  } dp_sts_t;

  function automatic logic [BYTE_W-1:0] hdr_byte(input logic [BYTE_CNT_W-1:0] idx,
                                                 input logic [31:0] fsize,
                                                 input logic [31:0] w,
                                                 input logic [31:0] h);
    logic [BYTE_W-1:0] b;
    b = '0;
    case (idx)
      6'd0:    b = MAGIC_B;
      6'd1:    b = MAGIC_M;
      6'd2:    b = fsize[7:0];
      6'd3:    b = fsize[15:8];
      6'd4:    b = fsize[23:16];
      6'd5:    b = fsize[31:24];
      6'd10:   b = BYTE_W'(HDR_BYTES);
      6'd14:   b = BYTE_W'(INFO_BYTES);
      6'd18:   b = w[7:0];
      6'd19:   b = w[15:8];
      6'd20:   b = w[23:16];
      6'd21:   b = w[31:24];
      6'd22:   b = h[7:0];
      6'd23:   b = h[15:8];
      6'd24:   b = h[23:16];
      6'd25:   b = h[31:24];
      6'd26:   b = BYTE_W'(PLANES);
      6'd28:   b = BYTE_W'(BITS_PER_PIXEL);
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bmpw_ctrl.sv
// Controller state machine of the BMP pixel stream writer.
// Sequences pixel intake, square root, header, pixel and padding bytes; uses bmpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmpw_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output bmpw_pkg::dp_cmd_t      cmd_o,
  input  wire bmpw_pkg::dp_sts_t sts_i
);
  import bmpw_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROOT = 3'd1;
  localparam logic [2:0] ST_HDR  = 3'd2;
  localparam logic [2:0] ST_PIX  = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.sel = SEL_HDR;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (sts_i.root_done) begin
          state_d = sts_i.need_hdr ? ST_HDR : ST_PIX;
        end
      end
      ST_HDR: begin
        cmd_o.sel = SEL_HDR;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.phase_last) begin
            state_d = ST_PIX;
          end
        end
      end
      ST_PIX: begin
        cmd_o.sel = SEL_PIX;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.phase_last) begin
            state_d = sts_i.need_pad ? ST_PAD : ST_IDLE;
          end
        end
      end
      ST_PAD: begin
        cmd_o.sel = SEL_PAD;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.phase_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/bmpw_dp.sv
// Datapath of the BMP pixel stream writer: configuration registers, frame counters,
// three-lane square root, header byte generation and the output register; uses bmpw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmpw_dp #(
  parameter int unsigned MAX_SIDE  = bmpw_pkg::MAX_SIDE_DEF,
  parameter int unsigned FRAC_BITS = bmpw_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bmpw_pkg::pixel_t               in_word_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [bmpw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bmpw_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output bmpw_pkg::bmp_word_t                 out_word_o,
  input  wire bmpw_pkg::dp_cmd_t              cmd_i,
  output bmpw_pkg::dp_sts_t                   sts_o
);
  import bmpw_pkg::*;

  localparam int unsigned SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int unsigned CNT_W   = $clog2(MAX_SIDE);
  localparam int unsigned RB_W    = SIDE_W + 2;
  localparam int unsigned PROD_W  = RB_W + SIDE_W;
  localparam int unsigned SHIFT   = DATA_W - FRAC_BITS;
  localparam int unsigned LANES   = 3;
  localparam logic [1:0]  ROOT_LAST = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [10:0]       rem;
    logic [7:0]        root;
  } root_lane_t;

  // Two result bits of the restoring square root per call.
  function automatic root_lane_t root_step2(input root_lane_t s);
    root_lane_t r;
    logic [9:0] trial;
    r = s;
    for (int j = 0; j < 2; j++) begin
      r.rem = {r.rem[8:0], r.x[DATA_W-1:DATA_W-2]};
      r.x   = {r.x[DATA_W-3:0], 2'b00};
      trial = {r.root, 2'b01};
      if (r.rem >= {1'b0, trial}) begin
        r.rem  = r.rem - {1'b0, trial};
        r.root = {r.root[6:0], 1'b1};
      end else begin
        r.root = {r.root[6:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [CFG_W-1:0]      width_q, height_q;
  logic [SIDE_W-1:0]     w_used, h_used;
  logic [RB_W-1:0]       rb, rb_q;
  logic [PROD_W-1:0]     prod;
  logic [31:0]           fsize_q;
  logic [1:0]            pad;

  logic [CNT_W-1:0]      col_q, col_d, row_q, row_d;
  logic                  row_end, frame_end;
  logic                  need_hdr_q, row_end_q, frame_end_q;

  logic [DATA_W-1:0]     chan_bits [LANES];
  root_lane_t            lane_q [LANES];
  root_lane_t            lane_d [LANES];
  logic                  sat_q [LANES];
  logic                  sat_d [LANES];
  logic [BYTE_W-1:0]     lane_byte [LANES];
  logic [1:0]            step_q;

  logic [BYTE_CNT_W-1:0] cnt_q, cnt_d;
  logic                  phase_last;
  logic                  run_last;
  logic [BYTE_W-1:0]     next_byte;
  logic                  out_valid_q;
  bmp_word_t             out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIDE_RESET;
      height_q <= SIDE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_used = SIDE_W'(1);
    end else if (32'(width_q) > 32'(MAX_SIDE)) begin
      w_used = SIDE_W'(MAX_SIDE);
    end else begin
      w_used = SIDE_W'(width_q);
    end
    if (height_q == '0) begin
      h_used = SIDE_W'(1);
    end else if (32'(height_q) > 32'(MAX_SIDE)) begin
      h_used = SIDE_W'(MAX_SIDE);
    end else begin
      h_used = SIDE_W'(height_q);
    end
  end

  // Padding to a multiple of four is the side modulo four, since 3w + w is 4w.
  assign pad  = w_used[1:0];
  assign rb   = RB_W'(w_used) * RB_W'(3) + RB_W'(pad);
  assign prod = rb_q * PROD_W'(h_used);

  always_ff @(posedge clk_i) begin
    rb_q    <= rb;
    fsize_q <= 32'(HDR_BYTES) + 32'(prod);
  end

  assign row_end   = (SIDE_W'(col_q) + SIDE_W'(1)) >= w_used;
  assign frame_end = row_end && ((SIDE_W'(row_q) + SIDE_W'(1)) >= h_used);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.load) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      need_hdr_q  <= 1'b0;
      row_end_q   <= 1'b0;
      frame_end_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cmd_i.load) begin
        need_hdr_q  <= (col_q == '0) && (row_q == '0);
        row_end_q   <= row_end;
        frame_end_q <= frame_end;
      end
    end
  end

  assign chan_bits[0] = in_word_i.blue_linear;
  assign chan_bits[1] = in_word_i.green_linear;
  assign chan_bits[2] = in_word_i.red_linear;

  always_comb begin
    logic [DATA_W+7:0] xw;
    for (int i = 0; i < LANES; i++) begin
      lane_d[i] = lane_q[i];
      sat_d[i]  = sat_q[i];
      xw = {8'b0, chan_bits[i]} << SHIFT;
      if (cmd_i.load) begin
        lane_d[i].x    = chan_bits[i][DATA_W-1] ? '0 : xw[DATA_W-1:0];
        lane_d[i].rem  = '0;
        lane_d[i].root = '0;
        sat_d[i]       = !chan_bits[i][DATA_W-1] && (|xw[DATA_W+7:DATA_W]);
      end else if (cmd_i.root_step) begin
        lane_d[i] = root_step2(lane_q[i]);
      end
      lane_byte[i] = sat_q[i] ? 8'hFF : lane_q[i].root;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < LANES; i++) begin
      lane_q[i] <= lane_d[i];
      sat_q[i]  <= sat_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.load) begin
      step_q <= '0;
    end else if (cmd_i.root_step) begin
      step_q <= step_q + 2'd1;
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_HDR: phase_last = (cnt_q == BYTE_CNT_W'(HDR_BYTES - 1));
      SEL_PIX: phase_last = (cnt_q == BYTE_CNT_W'(PIXEL_BYTES - 1));
      SEL_PAD: phase_last = (cnt_q == BYTE_CNT_W'(pad) - BYTE_CNT_W'(1));
      default: phase_last = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_HDR: next_byte = hdr_byte(cnt_q, fsize_q, 32'(w_used), 32'(h_used));
      SEL_PIX: begin
        case (cnt_q[1:0])
          2'd0:    next_byte = lane_byte[0];
          2'd1:    next_byte = lane_byte[1];
          default: next_byte = lane_byte[2];
        endcase
      end
      default: next_byte = '0;
    endcase
  end

  assign run_last = phase_last &&
                    (((cmd_i.sel == SEL_PIX) && !(row_end_q && (pad != 2'd0))) ||
                     (cmd_i.sel == SEL_PAD));

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = '0;
    end else if (cmd_i.emit) begin
      cnt_d = phase_last ? '0 : cnt_q + BYTE_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.out_byte  <= next_byte;
      out_q.run_last  <= run_last;
      out_q.file_last <= run_last && frame_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  assign sts_o.root_done  = (step_q == ROOT_LAST);
  assign sts_o.need_hdr   = need_hdr_q;
  assign sts_o.need_pad   = row_end_q && (pad != 2'd0);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.phase_last = phase_last;

endmodule

`default_nettype wire

>>> rtl/core/bmp_pixel_stream_writer.sv
// Top level of the BMP pixel stream writer: joins the controller and the datapath.
// Depends on bmpw_pkg, bmpw_ctrl and bmpw_dp.
`timescale 1ns / 1ps
`default_nettype none

// Takes one linear RGB pixel at a time in scan order and sends the bytes of a
// 24-bit BMP file, one byte per word, in the order blue, green, red, with the
// 54-byte header ahead of the first pixel of each frame and zero padding after
// the last pixel of each row. Each pixel is taken, then its square root is
// computed, which resolves two result bits of all three channels per cycle,
// and then its bytes are sent through the single output register. The first
// pixel of a frame also sends the header, and the last pixel of a row sends
// its padding bytes, zero to three. The user must write width and height
// through the configuration port only while no pixel is in flight; the block
// itself does not enforce this.
module bmp_pixel_stream_writer #(
  parameter int unsigned MAX_SIDE  = bmpw_pkg::MAX_SIDE_DEF,
  parameter int unsigned FRAC_BITS = bmpw_pkg::FRAC_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire bmpw_pkg::pixel_t               in_word_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output bmpw_pkg::bmp_word_t                 out_word_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [bmpw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bmpw_pkg::CFG_W-1:0]     cfg_data_i
);
  import bmpw_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bmpw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bmpw_dp #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire

>>> rtl/core/bmpw_checker.sv
// Port-level checker for the BMP pixel stream writer and the bind that attaches it.
// Depends on bmpw_pkg and bmp_pixel_stream_writer.
`timescale 1ns / 1ps
`default_nettype none

module bmpw_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire bmpw_pkg::bmp_word_t out_word_o
);
  import bmpw_pkg::*;

  // A pixel is taken only when the previous one is fully handled.
  a_one_pixel_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second pixel taken while one is in flight");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  a_file_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.file_last |-> out_word_o.run_last)
    else $error("file end flagged on a word that does not end its pixel");

  // Within the bytes of one pixel the output never runs dry.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_word_o.run_last |=> out_valid_o)
    else $error("gap inside the bytes of one pixel");

endmodule

bind bmp_pixel_stream_writer bmpw_checker u_bmpw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for bmp_pixel_stream_writer: directed and random pixels,
// checked byte by byte against a predictor of the BMP file stream.
// Depends on bmpw_pkg and the bmp_pixel_stream_writer RTL.
`timescale 1ns / 1ps

module tb_top;
  import bmpw_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned LONG_HOLD    = 600;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned MAX_RUN      = 60;

  typedef enum logic {STEP_PIXEL, STEP_CONFIG} step_kind_e;

  typedef struct packed {
    step_kind_e             kind;
    logic [CFG_IDX_W-1:0]   reg_index;
    logic [CFG_W-1:0]       reg_value;
    pixel_t                 pix;
    logic                   calm;
    logic                   long_hold;
  } stim_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  pixel_t               in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  bmp_word_t            out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  stim_t       stim_queue[$];
  bmp_word_t   bmp_bytes_due[$];
  int unsigned stim_total = 0;
  int unsigned steps_done = 0;
  int unsigned bytes_due = 0;
  int unsigned bytes_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned rx_hold = 0;
  logic        calm_phase = 1'b0;
  logic        long_hold_req = 1'b0;
  logic        hold_done = 1'b0;

  logic [CFG_W-1:0] pred_width = SIDE_RESET;
  logic [CFG_W-1:0] pred_height = SIDE_RESET;
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  bmp_pixel_stream_writer u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] clamp_side(input logic [CFG_W-1:0] side);
    if (side == '0) return 32'd1;
    if (side > MAX_SIDE_DEF) return 32'(MAX_SIDE_DEF);
    return 32'(side);
  endfunction

  function automatic logic [7:0] gamma_byte(input logic signed [DATA_W-1:0] lin);
    logic [31:0] scaled;
    logic [31:0] root;
    logic [31:0] trial;
    if (lin <= 0) return 8'd0;
    scaled = 32'(lin) << (16 - FRAC_BITS_DEF);
    if (scaled >= 32'd65536) return 8'hFF;
    root = '0;
    for (int b = 7; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= scaled) root = trial;
    end
    return root[7:0];
  endfunction

  task automatic predict_pixel(input pixel_t pix, output int unsigned count);
    logic [7:0]  run_bytes [MAX_RUN];
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] pad;
    logic [31:0] fsize;
    logic [31:0] hdr_len;
    logic [31:0] info_len;
    logic        row_end;
    logic        frame_end;
    bmp_word_t   word;
    w        = clamp_side(pred_width);
    h        = clamp_side(pred_height);
    pad      = (32'd4 - ((w * 32'd3) & 32'd3)) & 32'd3;
    hdr_len  = 32'(HDR_BYTES);
    info_len = 32'(INFO_BYTES);
    count    = 0;
    for (int i = 0; i < MAX_RUN; i++) run_bytes[i] = 8'd0;
    if (col_pos == 0 && row_pos == 0) begin
      fsize = hdr_len + (w * 32'd3 + pad) * h;
      run_bytes[0] = MAGIC_B;
      run_bytes[1] = MAGIC_M;
      for (int i = 0; i < 4; i++) begin
        run_bytes[2 + i]  = fsize[8*i +: 8];
        run_bytes[10 + i] = hdr_len[8*i +: 8];
        run_bytes[14 + i] = info_len[8*i +: 8];
        run_bytes[18 + i] = w[8*i +: 8];
        run_bytes[22 + i] = h[8*i +: 8];
      end
      run_bytes[26] = 8'(PLANES);
      run_bytes[28] = 8'(BITS_PER_PIXEL);
      count = HDR_BYTES;
    end
    run_bytes[count]     = gamma_byte(pix.blue_linear);
    run_bytes[count + 1] = gamma_byte(pix.green_linear);
    run_bytes[count + 2] = gamma_byte(pix.red_linear);
    count = count + PIXEL_BYTES;
    row_end   = (col_pos + 1 >= w);
    frame_end = row_end && (row_pos + 1 >= h);
    if (row_end) begin
      count   = count + pad;
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    for (int i = 0; i < count; i++) begin
      word.out_byte  = run_bytes[i];
      word.run_last  = (i == count - 1);
      word.file_last = frame_end && (i == count - 1);
      bmp_bytes_due.push_back(word);
    end
  endtask

  task automatic queue_config(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] value);
    stim_t s;
    s           = '0;
    s.kind      = STEP_CONFIG;
    s.reg_index = index;
    s.reg_value = value;
    stim_queue.push_back(s);
  endtask

  task automatic queue_pixel(input logic [DATA_W-1:0] red, input logic [DATA_W-1:0] green,
                             input logic [DATA_W-1:0] blue, input logic calm,
                             input logic long_hold);
    stim_t s;
    s                  = '0;
    s.kind             = STEP_PIXEL;
    s.pix.red_linear   = red;
    s.pix.green_linear = green;
    s.pix.blue_linear  = blue;
    s.calm             = calm;
    s.long_hold        = long_hold;
    stim_queue.push_back(s);
  endtask

  function automatic logic [DATA_W-1:0] rand_channel();
    case ($urandom_range(0, 6))
      0:       return DATA_W'($urandom_range(1, 600));
      1:       return DATA_W'($urandom_range(3900, 4200));
      2:       return 16'h8000 | DATA_W'($urandom);
      3:       return ($urandom_range(0, 1) == 0) ? 16'h7FFF : 16'h0000;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_side(input int unsigned typical_max);
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return CFG_W'(MAX_SIDE_DEF);
      2:       return '1;
      3:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(1, typical_max));
    endcase
  endfunction

  always @(posedge clk or negedge rst_n) begin : drive
    stim_t       nxt;
    int unsigned run_len;
    int unsigned done_now;
    logic        nxt_valid;
    logic        nxt_we;
    if (!rst_n) begin
      in_valid      <= 1'b0;
      cfg_we        <= 1'b0;
      tx_gap        <= 0;
      long_hold_req <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      nxt_we    = 1'b0;
      done_now  = 0;
      if (in_valid && !in_stall) begin
        predict_pixel(in_word, run_len);
        bytes_due <= bytes_due + run_len;
        done_now  = 1;
        nxt_valid = 1'b0;
      end
      if (!(in_valid && in_stall)) begin
        if (tx_gap != 0) begin
          tx_gap <= tx_gap - 1;
        end else if (stim_queue.size() != 0) begin
          nxt = stim_queue[0];
          if (nxt.kind == STEP_CONFIG) begin
            if (!in_valid && bytes_due == bytes_seen) begin
              nxt_we    = 1'b1;
              cfg_index <= nxt.reg_index;
              cfg_data  <= nxt.reg_value;
              if (nxt.reg_index == CFG_IMAGE_WIDTH) pred_width = nxt.reg_value;
              else pred_height = nxt.reg_value;
              done_now = 1;
              void'(stim_queue.pop_front());
            end
          end else begin
            nxt_valid  = 1'b1;
            in_word    <= nxt.pix;
            calm_phase <= nxt.calm;
            tx_gap     <= nxt.calm ? 0 : $urandom_range(0, 7);
            if (nxt.long_hold) long_hold_req <= 1'b1;
            void'(stim_queue.pop_front());
          end
        end
      end
      in_valid   <= nxt_valid;
      cfg_we     <= nxt_we;
      steps_done <= steps_done + done_now;
    end
  end

  always @(posedge clk or negedge rst_n) begin : receive
    int unsigned draw;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait   <= 0;
      rx_hold   <= 0;
      hold_done <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_stall <= (rx_hold != 1);
    end else if (long_hold_req && !hold_done) begin
      hold_done <= 1'b1;
      rx_hold   <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (rx_wait != 0) begin
      rx_wait   <= rx_wait - 1;
      out_stall <= (rx_wait != 1);
    end else if (out_valid && !out_stall) begin
      draw      = calm_phase ? 0 : $urandom_range(0, 7);
      rx_wait   <= draw;
      out_stall <= (draw != 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk or negedge rst_n) begin : check
    bmp_word_t want;
    if (!rst_n) begin
      bytes_seen <= 0;
    end else if (out_valid && !out_stall) begin
      bytes_seen <= bytes_seen + 1;
      if (bmp_bytes_due.size() == 0) begin
        $display("%0t: unexpected word, got byte %02h run_last %0b file_last %0b",
                 $time, out_word.out_byte, out_word.run_last, out_word.file_last);
        error_count++;
      end else begin
        want = bmp_bytes_due.pop_front();
        if (out_word.out_byte !== want.out_byte) begin
          $display("%0t: out_byte expected %02h, got %02h",
                   $time, want.out_byte, out_word.out_byte);
          error_count++;
        end
        if (out_word.run_last !== want.run_last) begin
          $display("%0t: run_last expected %0b, got %0b",
                   $time, want.run_last, out_word.run_last);
          error_count++;
        end
        if (out_word.file_last !== want.file_last) begin
          $display("%0t: file_last expected %0b, got %0b",
                   $time, want.file_last, out_word.file_last);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned pixels;
    queue_pixel(16'h7FFF, 16'h8000, 16'h0000, 1'b0, 1'b0);
    queue_config(CFG_IMAGE_WIDTH, 13'd1);
    queue_config(CFG_IMAGE_HEIGHT, 13'd1);
    queue_pixel(16'd1, 16'd4095, 16'd4096, 1'b0, 1'b0);
    queue_pixel(16'hFFFF, 16'd16, 16'd100, 1'b0, 1'b0);
    queue_config(CFG_IMAGE_WIDTH, 13'd0);
    queue_config(CFG_IMAGE_HEIGHT, 13'd0);
    queue_pixel(16'd4080, 16'd4097, 16'd2, 1'b0, 1'b0);
    queue_config(CFG_IMAGE_WIDTH, 13'd2);
    queue_config(CFG_IMAGE_HEIGHT, 13'd2);
    repeat (4) queue_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, 1'b0);
    queue_config(CFG_IMAGE_WIDTH, 13'd3);
    queue_config(CFG_IMAGE_HEIGHT, 13'd1);
    repeat (3) queue_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, 1'b0);
    queue_config(CFG_IMAGE_WIDTH, 13'd4);
    queue_config(CFG_IMAGE_HEIGHT, 13'd3);
    repeat (5) queue_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, 1'b0);
    // Shrink the frame under the running counts so the row and then the frame end early.
    queue_config(CFG_IMAGE_WIDTH, 13'd1);
    queue_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, 1'b0);
    queue_config(CFG_IMAGE_HEIGHT, 13'd1);
    queue_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, 1'b0);
    queue_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, 1'b0);
    queue_config(CFG_IMAGE_WIDTH, 13'h1FFF);
    queue_config(CFG_IMAGE_HEIGHT, 13'd4096);
    repeat (2) queue_pixel(rand_channel(), rand_channel(), rand_channel(), 1'b0, 1'b0);

    for (int phase = 0; phase < 8; phase++) begin
      queue_config(CFG_IMAGE_WIDTH, rand_side(6));
      queue_config(CFG_IMAGE_HEIGHT, rand_side(4));
      pixels = $urandom_range(9, 11);
      for (int i = 0; i < pixels; i++) begin
        queue_pixel(rand_channel(), rand_channel(), rand_channel(),
                    phase == 3 || phase == 6, phase == 2 && i == 2);
      end
    end
    stim_total = stim_queue.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (steps_done != stim_total || bytes_seen < bytes_due) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bmp_bytes_due.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, bmp_bytes_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
